FILE: rtl/tcw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg: shared definitions for the text console writer
// Character codes, reset values, field widths, mode codes and the control
// group passed from the cursor unit to the screen store.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // character codes
    localparam logic [7:0] CH_NEWLINE         = 8'h0A;
    localparam logic [7:0] CH_BACKSPACE       = 8'h08;
    localparam logic [7:0] CH_FIRST_PRINTABLE = 8'h20;

    // attribute register reset value
    localparam logic [7:0] ATTR_RESET = 8'h07;

    // item field widths
    localparam int MODE_W   = 2;
    localparam int CODE_W   = 8;
    localparam int RROW_W   = 5;
    localparam int RCOL_W   = 7;
    localparam int OCOL_W   = 7;
    localparam int OROW_W   = 5;
    localparam int OLOC_W   = 11;
    localparam int IN_DW    = 24;
    localparam int OUT_DW   = 40;

    // item modes; the fourth code is unused and changes nothing
    typedef enum logic [MODE_W-1:0] {
        MODE_PUT   = 2'd0,
        MODE_READ  = 2'd1,
        MODE_CLEAR = 2'd2
    } t_mode;

    // sequencer states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } t_state;

    // cursor unit control toward the store and the output stage
    typedef struct packed {
        logic cell_we;
        logic fill_we;
        logic scrolled;
    } t_cur_ctl;

endpackage
`default_nettype wire

FILE: rtl/tcw_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_store: screen cell memory and per-row fill memory
// Both memories are indexed by physical ring row, take one write and one
// read per cycle, and return registered read data in the cycle after the request.
// ----------------------------------------------------------------------------
module tcw_store #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF,
    localparam int CW     = $clog2(COLUMNS),
    localparam int RW     = $clog2(ROWS),
    localparam int FW     = $clog2(COLUMNS + 1),
    localparam int AW     = $clog2(ROWS * COLUMNS)
) (
    input  wire logic             i_clk,
    input  wire tcw_pkg::t_cur_ctl i_ctl,
    input  wire logic [RW-1:0]    i_wr_row,
    input  wire logic [CW-1:0]    i_wr_col,
    input  wire logic [15:0]      i_wr_cell,
    input  wire logic [FW-1:0]    i_wr_fill,
    input  wire logic             i_rd_en,
    input  wire logic [RW-1:0]    i_rd_row,
    input  wire logic [CW-1:0]    i_rd_col,
    output logic      [15:0]      o_rd_cell,
    output logic      [FW-1:0]    o_rd_fill
);

    logic [15:0]   r_cells [ROWS*COLUMNS];
    logic [FW-1:0] r_fills [ROWS];
    logic [AW-1:0] w_wr_addr;
    logic [AW-1:0] w_rd_addr;

    // linear cell address: physical row times columns plus column
    assign w_wr_addr = AW'(i_wr_row) * AW'(COLUMNS) + AW'(i_wr_col);
    assign w_rd_addr = AW'(i_rd_row) * AW'(COLUMNS) + AW'(i_rd_col);

    // cell memory
    always_ff @(posedge i_clk) begin
        if (i_ctl.cell_we) begin
            r_cells[w_wr_addr] <= i_wr_cell;
        end
        if (i_rd_en) begin
            o_rd_cell <= r_cells[w_rd_addr];
        end
    end

    // written-prefix length of each physical row
    always_ff @(posedge i_clk) begin
        if (i_ctl.fill_we) begin
            r_fills[i_wr_row] <= i_wr_fill;
        end
        if (i_rd_en) begin
            o_rd_fill <= r_fills[i_rd_row];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/tcw_cursor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_cursor: cursor, ring top pointer and fill count of the cursor row
// Applies a put or a clear and issues the cell and fill writes.
// Cells written in a row always form a prefix from column 0, so the row's
// fill count stands in for per-cell valid bits.
// ----------------------------------------------------------------------------
module tcw_cursor #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF,
    localparam int CW     = $clog2(COLUMNS),
    localparam int RW     = $clog2(ROWS),
    localparam int FW     = $clog2(COLUMNS + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_put,
    input  wire logic              i_clear,
    input  wire logic [7:0]        i_code,
    input  wire logic [7:0]        i_attr,
    output logic      [RW-1:0]     o_row,
    output logic      [RW-1:0]     o_top,
    output logic      [FW-1:0]     o_fill,
    output logic      [CW-1:0]     o_nxt_col,
    output logic      [RW-1:0]     o_nxt_row,
    output tcw_pkg::t_cur_ctl      o_ctl,
    output logic      [RW-1:0]     o_wr_row,
    output logic      [CW-1:0]     o_wr_col,
    output logic      [15:0]       o_wr_cell,
    output logic      [FW-1:0]     o_wr_fill
);

    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [RW-1:0] r_top, n_top;
    logic [FW-1:0] r_fill, n_fill;
    logic [RW:0]   w_sum;
    logic          w_nl, w_bs, w_print, w_last_col, w_last_row, w_adv;
    logic [FW-1:0] w_fill_upd;

    // physical row of the cursor row
    assign w_sum    = {1'b0, r_top} + {1'b0, r_row};
    assign o_wr_row = (w_sum >= (RW+1)'(ROWS)) ? RW'(w_sum - (RW+1)'(ROWS)) : RW'(w_sum);

    // character class
    assign w_nl    = (i_code == tcw_pkg::CH_NEWLINE);
    assign w_bs    = (i_code == tcw_pkg::CH_BACKSPACE);
    assign w_print = (i_code >= tcw_pkg::CH_FIRST_PRINTABLE);

    assign w_last_col = (r_col == CW'(COLUMNS - 1));
    assign w_last_row = (r_row == RW'(ROWS - 1));
    assign w_adv      = w_nl || (w_print && w_last_col);

    // printing at the end of the prefix grows it
    assign w_fill_upd = (w_print && (FW'(r_col) == r_fill)) ? r_fill + FW'(1) : r_fill;

    // next cursor state
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_top = r_top;
        n_fill = r_fill;
        if (i_clear) begin
            n_col  = '0;
            n_row  = '0;
            n_top  = '0;
            n_fill = '0;
        end else if (i_put) begin
            if (w_nl) begin
                n_col = '0;
            end else if (w_bs) begin
                if (r_col != '0) begin
                    n_col = r_col - CW'(1);
                end
            end else if (w_print) begin
                n_col = w_last_col ? '0 : r_col + CW'(1);
            end
            if (w_adv) begin
                // the row entered is always blank
                n_fill = '0;
                if (w_last_row) begin
                    n_top = (r_top == RW'(ROWS - 1)) ? '0 : r_top + RW'(1);
                end else begin
                    n_row = r_row + RW'(1);
                end
            end else begin
                n_fill = w_fill_upd;
            end
        end
    end

    // cursor registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_top  <= '0;
            r_fill <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_top  <= n_top;
            r_fill <= n_fill;
        end
    end

    // store writes: the fill of the row is saved on every put
    assign o_ctl.cell_we  = i_put && w_print;
    assign o_ctl.fill_we  = i_put;
    assign o_ctl.scrolled = i_put && w_adv && w_last_row;
    assign o_wr_col       = r_col;
    assign o_wr_cell      = {i_attr, i_code};
    assign o_wr_fill      = w_fill_upd;

    assign o_row     = r_row;
    assign o_top     = r_top;
    assign o_fill    = r_fill;
    assign o_nxt_col = n_col;
    assign o_nxt_row = n_row;

    // cursor stays on screen and never runs past the written prefix
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) < COLUMNS) else $error("cursor column out of range");
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_row) < ROWS && 32'(r_top) < ROWS) else $error("row or top out of range");
    a_fill_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        FW'(r_col) <= r_fill) else $error("cursor past written prefix");
    a_scroll_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.scrolled |=> (r_row == RW'(ROWS - 1)) && (r_fill == '0))
        else $error("scroll did not land on blank bottom row");

endmodule
`default_nettype wire

FILE: rtl/text_console_writer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer: character-cell text console with a scrolling line ring
// Top level: item sequencer, attribute register and output register.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on the s_axis channel; the mode is in tuser (put,
//   read, clear). Every item gives exactly one result item on m_axis with the
//   cursor, its linear location, a scroll flag and, for reads, the cell.
//   The attribute used by printed characters is written on the cfg channel,
//   which is always ready and should be written only while the block idles.
// Timing:
//   For a put, a clear or the unused mode the result is valid the cycle after
//   acceptance. For a read, the cell and row-fill memories return registered
//   data in the cycle after the address while the sequencer is in the read
//   state, and the result is then loaded into the output register; no item is
//   taken in the read state. Scrolling is constant time: the ring top pointer moves.
// Reset:
//   Synchronous, active low. Cursor and ring pointer go to zero, the screen
//   reads blank at once (no clearing pass) and the attribute returns to 07h.
// Backpressure:
//   One output register; a new item is taken in the same cycle as the
//   waiting result is taken. While the result waits, s_axis_tready is low.
// ----------------------------------------------------------------------------
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // configuration: text attribute
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [7:0]                  i_cfg_data,
    // input items
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // char_code[7:0], read_row[12:8], read_col[19:13], zero fill
    input  wire logic [tcw_pkg::IN_DW-1:0]   s_axis_tdata,
    // mode[1:0]
    input  wire logic [tcw_pkg::MODE_W-1:0]  s_axis_tuser,
    // result items
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // cursor_column[6:0], cursor_line[11:7], cursor_location[22:12],
    // scrolled[23], cell_char[31:24], cell_attr[39:32]
    output logic      [tcw_pkg::OUT_DW-1:0]  m_axis_tdata
);

    localparam int CW = $clog2(COLUMNS);
    localparam int RW = $clog2(ROWS);
    localparam int FW = $clog2(COLUMNS + 1);
    localparam int AW = $clog2(ROWS * COLUMNS);

    tcw_pkg::t_state   r_state, n_state;
    tcw_pkg::t_mode    w_mode;
    tcw_pkg::t_cur_ctl w_ctl;
    logic [7:0]        r_attr;
    logic              r_out_valid, n_out_valid;
    logic [tcw_pkg::OUT_DW-1:0] r_out_data, n_out_data;
    logic              w_in_ready, w_put, w_clear, w_rd_en;
    logic [7:0]        w_code;
    logic [tcw_pkg::RROW_W-1:0] w_rrow;
    logic [tcw_pkg::RCOL_W-1:0] w_rcol;

    logic [RW-1:0]     w_row, w_top, w_nxt_row, w_wr_row;
    logic [CW-1:0]     w_nxt_col, w_wr_col;
    logic [FW-1:0]     w_fill, w_wr_fill, w_rd_fill;
    logic [15:0]       w_wr_cell, w_rd_cell;
    logic [AW-1:0]     w_loc;

    logic [RW-1:0]     w_rd_srow, w_rd_prow;
    logic [CW-1:0]     w_rd_col;
    logic [RW:0]       w_rd_sum;
    logic              w_rd_ok;
    logic [RW-1:0]     r_rd_row;
    logic [CW-1:0]     r_rd_col;
    logic              r_rd_ok;
    logic              w_cell_valid;
    logic [15:0]       w_cell;

    // field unpacking
    assign w_mode = tcw_pkg::t_mode'(s_axis_tuser);
    assign w_code = s_axis_tdata[7:0];
    assign w_rrow = s_axis_tdata[12:8];
    assign w_rcol = s_axis_tdata[19:13];

    // attribute register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= tcw_pkg::ATTR_RESET;
        end else if (i_cfg_valid) begin
            r_attr <= i_cfg_data;
        end
    end

    // cursor unit
    tcw_cursor #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_cursor (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_put     (w_put),
        .i_clear   (w_clear),
        .i_code    (w_code),
        .i_attr    (r_attr),
        .o_row     (w_row),
        .o_top     (w_top),
        .o_fill    (w_fill),
        .o_nxt_col (w_nxt_col),
        .o_nxt_row (w_nxt_row),
        .o_ctl     (w_ctl),
        .o_wr_row  (w_wr_row),
        .o_wr_col  (w_wr_col),
        .o_wr_cell (w_wr_cell),
        .o_wr_fill (w_wr_fill)
    );

    // read address: screen row mapped through the ring
    assign w_rd_ok   = (32'(w_rrow) < ROWS) && (32'(w_rcol) < COLUMNS);
    assign w_rd_srow = RW'(w_rrow);
    assign w_rd_col  = CW'(w_rcol);
    assign w_rd_sum  = {1'b0, w_top} + {1'b0, w_rd_srow};
    assign w_rd_prow = (w_rd_sum >= (RW+1)'(ROWS)) ?
                       RW'(w_rd_sum - (RW+1)'(ROWS)) : RW'(w_rd_sum);

    // screen store; reads and writes never share a cycle
    tcw_store #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_store (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_wr_row  (w_wr_row),
        .i_wr_col  (w_wr_col),
        .i_wr_cell (w_wr_cell),
        .i_wr_fill (w_wr_fill),
        .i_rd_en   (w_rd_en),
        .i_rd_row  (w_rd_prow),
        .i_rd_col  (w_rd_col),
        .o_rd_cell (w_rd_cell),
        .o_rd_fill (w_rd_fill)
    );

    // read request held for the data cycle
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_row <= w_rd_srow;
            r_rd_col <= w_rd_col;
            r_rd_ok  <= w_rd_ok;
        end
    end

    // rows above the cursor use the saved fill, the cursor row the live one,
    // rows below the cursor are blank
    assign w_cell_valid = r_rd_ok &&
        (((r_rd_row < w_row) && (FW'(r_rd_col) < w_rd_fill)) ||
         ((r_rd_row == w_row) && (FW'(r_rd_col) < w_fill)));
    assign w_cell = w_cell_valid ? w_rd_cell : 16'h0000;

    // hardware cursor location
    assign w_loc = AW'(w_nxt_row) * AW'(COLUMNS) + AW'(w_nxt_col);

    // sequencer and output register load
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        w_in_ready  = 1'b0;
        w_put       = 1'b0;
        w_clear     = 1'b0;
        w_rd_en     = 1'b0;
        case (r_state)
            tcw_pkg::ST_IDLE: begin
                w_in_ready = !r_out_valid || m_axis_tready;
                if (s_axis_tvalid && w_in_ready) begin
                    case (w_mode)
                        tcw_pkg::MODE_PUT:   w_put   = 1'b1;
                        tcw_pkg::MODE_READ:  w_rd_en = 1'b1;
                        tcw_pkg::MODE_CLEAR: w_clear = 1'b1;
                        default: ;
                    endcase
                    if (w_mode == tcw_pkg::MODE_READ) begin
                        n_state = tcw_pkg::ST_READ;
                    end else begin
                        n_out_valid = 1'b1;
                        n_out_data  = {16'h0000, w_ctl.scrolled,
                                       tcw_pkg::OLOC_W'(w_loc),
                                       tcw_pkg::OROW_W'(w_nxt_row),
                                       tcw_pkg::OCOL_W'(w_nxt_col)};
                    end
                end
            end
            tcw_pkg::ST_READ: begin
                n_out_valid = 1'b1;
                n_out_data  = {w_cell[15:8], w_cell[7:0], 1'b0,
                               tcw_pkg::OLOC_W'(w_loc),
                               tcw_pkg::OROW_W'(w_nxt_row),
                               tcw_pkg::OCOL_W'(w_nxt_col)};
                n_state     = tcw_pkg::ST_IDLE;
            end
            default: begin
                n_state = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcw_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign s_axis_tready = w_in_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // a read in flight owns the empty output register
    a_read_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tcw_pkg::ST_READ |-> !r_out_valid && !w_ctl.fill_we)
        else $error("read data cycle with output busy or store write");
    a_read_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_en |=> r_state == tcw_pkg::ST_READ && !m_axis_tvalid)
        else $error("read issue not followed by data cycle");

endmodule
`default_nettype wire
